/* rtl/saswin_pkg.sv */
`default_nettype none
package saswin_pkg;

	localparam int SEQ_W   = 16;
	localparam int BYTES_W = 11;
	localparam int POS_W   = 4;
	localparam int SLOT_W  = 3;
	localparam int MAX_OUT = 8;
	localparam int CNT_W   = $clog2(MAX_OUT);

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_ACK     = 2'd1,
		ACT_ADVANCE = 2'd2,
		ACT_SEND    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		EMIT_NONE   = 2'd0,
		EMIT_STATUS = 2'd1,
		EMIT_ENTRY  = 2'd2
	} emit_t;

	typedef struct packed {
		logic  capture;
		logic  insert;
		logic  ack_clear;
		logic  ok_set;
		logic  head_step;
		logic  shift_step;
		logic  shift_finish;
		logic  idx_inc;
		emit_t emit;
	} ctrl_cmd_t;

	typedef struct packed {
		action_t act;
		logic    full;
		logic    empty;
		logic    idx_end;
		logic    idx_valid;
		logic    hit;
		logic    at_head;
		logic    head_stop;
		logic    shift_done;
		logic    last_hit;
		logic    out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/saswin_if.sv */
`default_nettype none
interface saswin_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [saswin_pkg::SEQ_W-1:0]   seq_number;
	logic [saswin_pkg::BYTES_W-1:0] packet_bytes;

	modport source (output valid, output action, output seq_number, output packet_bytes,
		input ready);
	modport sink (input valid, input action, input seq_number, input packet_bytes,
		output ready);
endinterface

interface saswin_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic                          window_empty;
	logic [saswin_pkg::POS_W-1:0]   head_pos;
	logic [saswin_pkg::POS_W-1:0]   tail_pos;
	logic                          entry_valid;
	logic [saswin_pkg::SLOT_W-1:0]  entry_slot;
	logic [saswin_pkg::SEQ_W-1:0]   entry_seq;
	logic [saswin_pkg::BYTES_W-1:0] entry_bytes;
	logic                          last;

	modport source (output valid, output ok, output window_empty, output head_pos,
		output tail_pos, output entry_valid, output entry_slot, output entry_seq,
		output entry_bytes, output last, input ready);
	modport sink (input valid, input ok, input window_empty, input head_pos,
		input tail_pos, input entry_valid, input entry_slot, input entry_seq,
		input entry_bytes, input last, output ready);
endinterface
`default_nettype wire

/* rtl/saswin_ctrl.sv */
`default_nettype none
module saswin_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	output logic                       in_ready,
	input  wire saswin_pkg::dp_stat_t  st,
	output saswin_pkg::ctrl_cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_DISPATCH  = 7'b0000010,
		S_ACK_SCAN  = 7'b0000100,
		S_HEAD_WALK = 7'b0001000,
		S_SHIFT     = 7'b0010000,
		S_SEND_SCAN = 7'b0100000,
		S_FINISH    = 7'b1000000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.emit  = saswin_pkg::EMIT_NONE;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (st.act)
					saswin_pkg::ACT_INSERT: begin
						cmd.insert = !st.full;
						cmd.ok_set = !st.full;
						state_nxt  = S_FINISH;
					end
					saswin_pkg::ACT_ACK: begin
						state_nxt = S_ACK_SCAN;
					end
					saswin_pkg::ACT_ADVANCE: begin
						cmd.ok_set = 1'b1;
						state_nxt  = S_SHIFT;
					end
					saswin_pkg::ACT_SEND: begin
						if (st.empty) begin
							cmd.ok_set = 1'b1;
							state_nxt  = S_FINISH;
						end else begin
							state_nxt = S_SEND_SCAN;
						end
					end
				endcase
			end
			S_ACK_SCAN: begin
				priority if (st.idx_end) begin
					state_nxt = S_FINISH;
				end else if (st.hit) begin
					cmd.ack_clear = 1'b1;
					cmd.ok_set    = 1'b1;
					state_nxt     = st.at_head ? S_HEAD_WALK : S_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_HEAD_WALK: begin
				if (st.head_stop) begin
					state_nxt = S_FINISH;
				end else begin
					cmd.head_step = 1'b1;
				end
			end
			S_SHIFT: begin
				if (st.shift_done) begin
					cmd.shift_finish = 1'b1;
					state_nxt        = S_FINISH;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			S_SEND_SCAN: begin
				priority if (st.idx_end) begin
					state_nxt = S_IDLE;
				end else if (!st.idx_valid) begin
					cmd.idx_inc = 1'b1;
				end else if (st.out_free) begin
					cmd.emit    = saswin_pkg::EMIT_ENTRY;
					cmd.idx_inc = 1'b1;
					if (st.last_hit) begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.emit  = saswin_pkg::EMIT_STATUS;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/saswin_dp.sv */
`default_nettype none
module saswin_dp #(
	parameter int SLOTS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [1:0]                    action,
	input  wire logic [saswin_pkg::SEQ_W-1:0]   seq_number,
	input  wire logic [saswin_pkg::BYTES_W-1:0] packet_bytes,
	input  wire saswin_pkg::ctrl_cmd_t         ctl,
	output saswin_pkg::dp_stat_t               st,
	saswin_rsp_if.source                       rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	saswin_pkg::action_t             act_q;
	logic [saswin_pkg::SEQ_W-1:0]   key_q;
	logic [saswin_pkg::BYTES_W-1:0] size_q;

	logic [SLOTS-1:0]               valid_q;
	logic [saswin_pkg::SEQ_W-1:0]   seq_mem   [SLOTS];
	logic [saswin_pkg::BYTES_W-1:0] bytes_mem [SLOTS];
	logic [CW-1:0]                  head_q, tail_q, idx_q;
	logic [saswin_pkg::CNT_W-1:0]   cnt_q;
	logic                           ok_q;

	logic                           rsp_valid_q;
	logic                           o_ok_q, o_empty_q, o_ev_q, o_last_q;
	logic [saswin_pkg::POS_W-1:0]   o_head_q, o_tail_q;
	logic [saswin_pkg::SLOT_W-1:0]  o_slot_q;
	logic [saswin_pkg::SEQ_W-1:0]   o_seq_q;
	logic [saswin_pkg::BYTES_W-1:0] o_bytes_q;

	logic [IW-1:0]                  idx_a, head_a, tail_a, src_a, rd_a;
	logic [CW:0]                    src_sum;
	logic [saswin_pkg::SEQ_W-1:0]   rd_seq;
	logic [saswin_pkg::BYTES_W-1:0] rd_bytes;
	logic [SLOTS-1:0]               upper;
	logic [SLOTS-1:0]               valid_shift;
	logic [31:0]                    head_x, tail_x, idx_x;

	assign idx_a   = idx_q[IW-1:0];
	assign head_a  = head_q[IW-1:0];
	assign tail_a  = tail_q[IW-1:0];
	assign src_sum = {1'b0, idx_q} + {1'b0, head_q};
	assign src_a   = src_sum[IW-1:0];
	// during a shift the single read port looks at the source slot
	assign rd_a     = ctl.shift_step ? src_a : idx_a;
	assign rd_seq   = seq_mem[rd_a];
	assign rd_bytes = bytes_mem[rd_a];
	// valid slots strictly above the scan index
	assign upper    = (valid_q >> idx_q) >> 1;
	assign head_x   = 32'(head_q);
	assign tail_x   = 32'(tail_q);
	assign idx_x    = 32'(idx_q);

	// valid marks after one shift step: source mark moves down, source slot empties
	always_comb begin
		valid_shift        = valid_q;
		valid_shift[idx_a] = valid_q[src_a];
		valid_shift[src_a] = 1'b0;
	end

	always_comb begin
		st.act        = act_q;
		st.full       = (tail_q == CW'(SLOTS));
		st.empty      = (valid_q == '0);
		st.idx_end    = (idx_q == CW'(SLOTS));
		st.idx_valid  = valid_q[idx_a];
		st.hit        = valid_q[idx_a] && (rd_seq == key_q);
		st.at_head    = (idx_q == head_q);
		st.head_stop  = (head_q == CW'(SLOTS)) || valid_q[head_a];
		st.shift_done = (head_q == '0) || (src_sum >= (CW + 1)'(SLOTS));
		st.last_hit   = (upper == '0) ||
			(cnt_q == saswin_pkg::CNT_W'(saswin_pkg::MAX_OUT - 1));
		st.out_free   = !rsp_valid_q || rsp.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			ok_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				idx_q <= '0;
				cnt_q <= '0;
				ok_q  <= 1'b0;
			end
			if (ctl.ok_set) begin
				ok_q <= 1'b1;
			end
			if (ctl.insert) begin
				valid_q[tail_a] <= 1'b1;
				tail_q          <= tail_q + CW'(1);
			end
			if (ctl.ack_clear) begin
				valid_q[idx_a] <= 1'b0;
			end
			if (ctl.head_step) begin
				head_q <= head_q + CW'(1);
			end
			if (ctl.shift_step) begin
				valid_q <= valid_shift;
				idx_q   <= idx_q + CW'(1);
			end
			if (ctl.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (ctl.shift_finish) begin
				tail_q <= (tail_q > head_q) ? tail_q - head_q : '0;
				head_q <= '0;
			end
			if (ctl.emit == saswin_pkg::EMIT_ENTRY) begin
				cnt_q <= cnt_q + saswin_pkg::CNT_W'(1);
			end
			if (ctl.emit != saswin_pkg::EMIT_NONE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			act_q  <= saswin_pkg::action_t'(action);
			key_q  <= seq_number;
			size_q <= packet_bytes;
		end
		if (ctl.insert) begin
			seq_mem[tail_a]   <= key_q;
			bytes_mem[tail_a] <= size_q;
		end
		if (ctl.shift_step) begin
			seq_mem[idx_a]   <= rd_seq;
			bytes_mem[idx_a] <= rd_bytes;
		end
		unique case (ctl.emit)
			saswin_pkg::EMIT_STATUS: begin
				o_ok_q    <= ok_q;
				o_empty_q <= (valid_q == '0);
				o_head_q  <= head_x[saswin_pkg::POS_W-1:0];
				o_tail_q  <= tail_x[saswin_pkg::POS_W-1:0];
				o_ev_q    <= 1'b0;
				o_slot_q  <= '0;
				o_seq_q   <= '0;
				o_bytes_q <= '0;
				o_last_q  <= 1'b1;
			end
			saswin_pkg::EMIT_ENTRY: begin
				o_ok_q    <= 1'b1;
				o_empty_q <= (valid_q == '0);
				o_head_q  <= head_x[saswin_pkg::POS_W-1:0];
				o_tail_q  <= tail_x[saswin_pkg::POS_W-1:0];
				o_ev_q    <= 1'b1;
				o_slot_q  <= idx_x[saswin_pkg::SLOT_W-1:0];
				o_seq_q   <= rd_seq;
				o_bytes_q <= rd_bytes;
				o_last_q  <= st.last_hit;
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = o_ok_q;
	assign rsp.window_empty = o_empty_q;
	assign rsp.head_pos     = o_head_q;
	assign rsp.tail_pos     = o_tail_q;
	assign rsp.entry_valid  = o_ev_q;
	assign rsp.entry_slot   = o_slot_q;
	assign rsp.entry_seq    = o_seq_q;
	assign rsp.entry_bytes  = o_bytes_q;
	assign rsp.last         = o_last_q;

endmodule
`default_nettype wire

/* rtl/selective_ack_send_window.sv */
// one item at a time; scans and shift walk the table one slot per cycle by a shared index,
// the head walk steps head instead; a send scan holds its slot while the output is stalled
// insert: dispatch, then finish loads the result; advance: dispatch, shift, then finish
// ack: match scan, then a head walk if the head slot was acked; send: results leave as found
// a new item is taken once the previous one has loaded its final result
// reset clears valid marks, head and tail at once; no clearing pass
`default_nettype none
module selective_ack_send_window #(
	parameter int SLOTS = 8
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	saswin_cmd_if.sink   cmd,
	saswin_rsp_if.source rsp
);

	saswin_pkg::ctrl_cmd_t ctl;
	saswin_pkg::dp_stat_t  st;
	logic                  in_ready;

	assign cmd.ready = in_ready;

	saswin_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (cmd.valid && in_ready),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (ctl)
	);

	saswin_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.action       (cmd.action),
		.seq_number   (cmd.seq_number),
		.packet_bytes (cmd.packet_bytes),
		.ctl          (ctl),
		.st           (st),
		.rsp          (rsp)
	);

endmodule
`default_nettype wire

/* tb/tb_selective_ack_send_window.sv */
`timescale 1ns / 1ps
module tb_selective_ack_send_window;
	import saswin_pkg::*;

	localparam int SLOTS    = 8;
	localparam int WATCHDOG = 2000;
	localparam int DRAIN    = 2 * SLOTS + 8;

	typedef struct packed {
		logic               ok;
		logic               empty;
		logic [POS_W-1:0]   head;
		logic [POS_W-1:0]   tail;
		logic               ev;
		logic [SLOT_W-1:0]  slot;
		logic [SEQ_W-1:0]   seq;
		logic [BYTES_W-1:0] bytes;
		logic               last;
	} window_reply_t;

	logic clk = 1'b0;
	logic arst_n;

	saswin_cmd_if cmd ();
	saswin_rsp_if rsp ();

	selective_ack_send_window #(
		.SLOTS(SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// window copy kept by the predictor
	bit                 win_live[SLOTS];
	logic [SEQ_W-1:0]   win_seq[SLOTS];
	logic [BYTES_W-1:0] win_len[SLOTS];
	int unsigned        win_head;
	int unsigned        win_tail;

	window_reply_t window_reply_q[$];

	bit gaps_on = 1'b0;
	int errors = 0;
	int replies_seen = 0;
	int action_count[4];
	int stall_left = 0;
	int quiet_cycles = 0;
	int unsigned next_seq;

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic bit window_is_empty();
		for (int i = 0; i < SLOTS; i++)
			if (win_live[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic window_reply_t make_reply(logic ok, logic ev, int slot,
			logic [SEQ_W-1:0] seq, logic [BYTES_W-1:0] bytes, logic last);
		window_reply_t r;
		r.ok    = ok;
		r.empty = window_is_empty();
		r.head  = win_head[POS_W-1:0];
		r.tail  = win_tail[POS_W-1:0];
		r.ev    = ev;
		r.slot  = slot[SLOT_W-1:0];
		r.seq   = seq;
		r.bytes = bytes;
		r.last  = last;
		return r;
	endfunction

	task automatic predict_window(action_t act, logic [SEQ_W-1:0] seq,
			logic [BYTES_W-1:0] bytes);
		logic ok;
		int n_live;
		int k;
		ok = 1'b0;
		case (act)
			ACT_INSERT: begin
				if (win_tail < SLOTS) begin
					win_live[win_tail] = 1'b1;
					win_seq[win_tail]  = seq;
					win_len[win_tail]  = bytes;
					win_tail++;
					ok = 1'b1;
				end
				window_reply_q.push_back(make_reply(ok, 1'b0, 0, '0, '0, 1'b1));
			end
			ACT_ACK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (win_live[i] && win_seq[i] == seq) begin
						win_live[i] = 1'b0;
						// head sweeps forward only when the head slot itself was acked
						if (i == win_head)
							while (win_head < SLOTS && !win_live[win_head])
								win_head++;
						ok = 1'b1;
						break;
					end
				end
				window_reply_q.push_back(make_reply(ok, 1'b0, 0, '0, '0, 1'b1));
			end
			ACT_ADVANCE: begin
				if (win_head != 0) begin
					for (int i = 0; i + win_head < SLOTS; i++) begin
						win_live[i] = win_live[i + win_head];
						win_seq[i]  = win_seq[i + win_head];
						win_len[i]  = win_len[i + win_head];
						win_live[i + win_head] = 1'b0;
						win_len[i + win_head]  = '0;
					end
				end
				win_tail = (win_tail > win_head) ? win_tail - win_head : 0;
				win_head = 0;
				window_reply_q.push_back(make_reply(1'b1, 1'b0, 0, '0, '0, 1'b1));
			end
			default: begin
				n_live = 0;
				for (int i = 0; i < SLOTS; i++)
					if (win_live[i])
						n_live++;
				if (n_live > MAX_OUT)
					n_live = MAX_OUT;
				if (n_live == 0) begin
					window_reply_q.push_back(make_reply(1'b1, 1'b0, 0, '0, '0, 1'b1));
				end else begin
					k = 0;
					for (int i = 0; i < SLOTS && k < n_live; i++) begin
						if (win_live[i]) begin
							window_reply_q.push_back(make_reply(1'b1, 1'b1, i, win_seq[i],
								win_len[i], k == n_live - 1));
							k++;
						end
					end
				end
			end
		endcase
	endtask

	// hands one item to the block; valid stays high unless an idle burst follows
	task automatic send_item(action_t act, logic [SEQ_W-1:0] seq, logic [BYTES_W-1:0] bytes);
		cmd.valid        <= 1'b1;
		cmd.action       <= act;
		cmd.seq_number   <= seq;
		cmd.packet_bytes <= bytes;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		predict_window(act, seq, bytes);
		action_count[act]++;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic test_empty_window();
		send_item(ACT_SEND, 16'h0000, 11'h000);
		send_item(ACT_ACK, 16'h1234, 11'h000);
		send_item(ACT_ADVANCE, 16'h0000, 11'h000);
	endtask

	task automatic test_fill_and_overflow();
		send_item(ACT_INSERT, 16'h0000, 11'h000);
		send_item(ACT_INSERT, 16'hffff, 11'h7ff);
		send_item(ACT_INSERT, 16'h5555, 11'h555);
		send_item(ACT_INSERT, 16'haaaa, 11'h2aa);
		send_item(ACT_INSERT, 16'h0007, 11'h001);
		send_item(ACT_INSERT, 16'h0007, 11'h002);
		send_item(ACT_INSERT, 16'h8000, 11'h400);
		send_item(ACT_INSERT, 16'h0001, 11'h3ff);
		// window full: rejected
		send_item(ACT_INSERT, 16'hffff, 11'h7ff);
		send_item(ACT_SEND, 16'h0000, 11'h000);
	endtask

	task automatic test_acks_and_shift();
		send_item(ACT_ACK, 16'hffff, 11'h000);
		send_item(ACT_ACK, 16'h0000, 11'h000);
		// duplicate sequence number: only the first copy is cleared
		send_item(ACT_ACK, 16'h0007, 11'h000);
		send_item(ACT_ACK, 16'hbeef, 11'h000);
		send_item(ACT_ADVANCE, 16'h0000, 11'h000);
		send_item(ACT_SEND, 16'h0000, 11'h000);
	endtask

	task automatic test_head_past_tail();
		send_item(ACT_ACK, 16'haaaa, 11'h000);
		send_item(ACT_ACK, 16'h8000, 11'h000);
		send_item(ACT_ACK, 16'h0001, 11'h000);
		send_item(ACT_ACK, 16'h0007, 11'h000);
		// head slot acked last, head runs to the end of the table
		send_item(ACT_ACK, 16'h5555, 11'h000);
		send_item(ACT_ADVANCE, 16'h0000, 11'h000);
		send_item(ACT_SEND, 16'h0000, 11'h000);
	endtask

	task automatic test_random_traffic(int n_items);
		logic [SEQ_W-1:0]   live_seqs[$];
		logic [SEQ_W-1:0]   seq;
		logic [BYTES_W-1:0] bytes;
		action_t            act;
		int                 r;
		bit                 filling;
		for (int n = 0; n < n_items; n++) begin
			live_seqs.delete();
			for (int i = 0; i < SLOTS; i++)
				if (win_live[i])
					live_seqs.push_back(win_seq[i]);
			filling = ((n / 40) % 2) == 0;
			r = $urandom_range(0, 99);
			if (filling)
				act = (r < 50) ? ACT_INSERT : (r < 75) ? ACT_ACK :
					(r < 90) ? ACT_ADVANCE : ACT_SEND;
			else
				act = (r < 20) ? ACT_INSERT : (r < 70) ? ACT_ACK :
					(r < 85) ? ACT_ADVANCE : ACT_SEND;
			seq = $urandom;
			case ($urandom_range(0, 5))
				0: bytes = '0;
				1: bytes = '1;
				default: bytes = $urandom_range(0, 2047);
			endcase
			if (act == ACT_INSERT) begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					seq = next_seq[SEQ_W-1:0];
					next_seq++;
				end else if (r == 8 && live_seqs.size() != 0) begin
					seq = live_seqs[$urandom_range(0, live_seqs.size() - 1)];
				end else if (r == 9) begin
					seq = $urandom_range(0, 1) ? '1 : '0;
				end
			end else if (act == ACT_ACK) begin
				if (live_seqs.size() != 0 && $urandom_range(0, 4) != 0)
					seq = live_seqs[$urandom_range(0, live_seqs.size() - 1)];
			end
			send_item(act, seq, bytes);
		end
	endtask

	// response side: random stall bursts while gaps are on
	always @(posedge clk) begin
		if (stall_left != 0) begin
			rsp.ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			rsp.ready  <= 1'b0;
			stall_left <= $urandom_range(1, 14) - 1;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		window_reply_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			replies_seen++;
			if (window_reply_q.size() == 0) begin
				report_mismatch("result with nothing pending");
			end else begin
				want = window_reply_q.pop_front();
				check_field("ok", rsp.ok, want.ok);
				check_field("window_empty", rsp.window_empty, want.empty);
				check_field("head_pos", rsp.head_pos, want.head);
				check_field("tail_pos", rsp.tail_pos, want.tail);
				check_field("entry_valid", rsp.entry_valid, want.ev);
				check_field("entry_slot", rsp.entry_slot, want.slot);
				check_field("entry_seq", rsp.entry_seq, want.seq);
				check_field("entry_bytes", rsp.entry_bytes, want.bytes);
				check_field("last", rsp.last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG) begin
			$display("timeout after %0d idle cycles", quiet_cycles);
			$display("selective_ack_send_window verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cmd.valid        = 1'b0;
		cmd.action       = ACT_INSERT;
		cmd.seq_number   = '0;
		cmd.packet_bytes = '0;
		rsp.ready        = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			win_live[i] = 1'b0;
			win_seq[i]  = '0;
			win_len[i]  = '0;
		end
		win_head = 0;
		win_tail = 0;
		for (int i = 0; i < 4; i++)
			action_count[i] = 0;
		next_seq = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_window();
		test_fill_and_overflow();
		test_acks_and_shift();
		test_head_past_tail();
		gaps_on = 1'b1;
		test_random_traffic(360);
		// closing stretch at full rate on both sides
		gaps_on = 1'b0;
		test_random_traffic(60);
		cmd.valid <= 1'b0;

		while (window_reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d inserts, %0d acks, %0d advances, %0d sends",
			action_count[ACT_INSERT], action_count[ACT_ACK],
			action_count[ACT_ADVANCE], action_count[ACT_SEND]);
		$display("%0d results checked, %0d mismatches", replies_seen, errors);
		if (errors == 0 && window_reply_q.size() == 0) begin
			$display("selective_ack_send_window verification clean");
		end else begin
			$display("selective_ack_send_window verification failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/saswin_pkg.sv
rtl/saswin_if.sv
rtl/saswin_ctrl.sv
rtl/saswin_dp.sv
rtl/selective_ack_send_window.sv
tb/tb_selective_ack_send_window.sv
